[rtl/lca_pkg.sv]
// ----------------------------------------------------------------------------
// lca_pkg: shared types and constants
// Field widths, function codes and register indexes of the LCA block.
// ----------------------------------------------------------------------------
package lca_pkg;

  // Default sizing of the ancestor table.
  localparam int MAX_NODES_DEF = 1024;
  localparam int LEVELS_DEF    = 12;

  // Field widths.
  localparam int NODE_W  = 10;
  localparam int COUNT_W = 11;
  localparam int FUNC_W  = 2;
  localparam int CIDX_W  = 2;
  localparam int CDAT_W  = 11;

  typedef logic [NODE_W-1:0]  node_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [CIDX_W-1:0]  cidx_t;
  typedef logic [CDAT_W-1:0]  cdat_t;

  // Input function codes.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam cidx_t REG_NODE_COUNT = 2'd0;
  localparam cidx_t REG_ROOT_NODE  = 2'd1;

  localparam count_t COUNT_RST = 11'd1;
  localparam node_t  ROOT_RST  = 10'd0;

endpackage

[rtl/lca_in_if.sv]
// ----------------------------------------------------------------------------
// lca_in_if: input channel
// Carries one load, build, query or no-op word with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lca_in_if;
  logic                valid;
  logic                ready;
  lca_pkg::func_t      func;
  lca_pkg::node_t      node;
  lca_pkg::node_t      parent_node;
  lca_pkg::node_t      node_depth;
  lca_pkg::node_t      left_node;
  lca_pkg::node_t      right_node;

  modport source (output valid, func, node, parent_node, node_depth, left_node,
                  right_node, input ready);
  modport sink (input valid, func, node, parent_node, node_depth, left_node,
                right_node, output ready);
endinterface

[rtl/lca_out_if.sv]
// ----------------------------------------------------------------------------
// lca_out_if: result channel
// Carries the common ancestor and its depth with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lca_out_if;
  logic           valid;
  logic           ready;
  lca_pkg::node_t ancestor_node;
  lca_pkg::node_t ancestor_depth;

  modport source (output valid, ancestor_node, ancestor_depth, input ready);
  modport sink (input valid, ancestor_node, ancestor_depth, output ready);
endinterface

[rtl/lca_cfg_if.sv]
// ----------------------------------------------------------------------------
// lca_cfg_if: configuration write channel
// Carries a register index and write data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lca_cfg_if;
  logic           valid;
  logic           ready;
  lca_pkg::cidx_t index;
  lca_pkg::cdat_t data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/tree_lca_binary_lifting.sv]
// ----------------------------------------------------------------------------
// tree_lca_binary_lifting: lowest common ancestor by binary lifting
// Sequencer around an ancestor table memory and a depth memory.
// ----------------------------------------------------------------------------
// A load word writes a node's parent and depth. A build word fills the table
// for n = min(node_count, MAX_NODES) nodes, level by level, where each
// table entry costs two dependent reads of the single table read port and
// one write. A query first lifts the deeper node to the depth of the other.
// When the nodes have met by then, a check hands over the result.
// Otherwise a joint lifting follows, then the final parent read, the depth
// read and the hand-off. One word is processed at a time. A finished result
// sits in an output register so the next word can be taken while it waits.
// Table and depth entries must be loaded before a build or query reads them.
module tree_lca_binary_lifting #(
  parameter int MAX_NODES = lca_pkg::MAX_NODES_DEF,
  parameter int LEVELS    = lca_pkg::LEVELS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lca_in_if.sink     in_ch,
  lca_out_if.source  out_ch,
  lca_cfg_if.sink    cfg_ch
);

  localparam int AW  = $clog2(MAX_NODES);
  localparam int LW  = $clog2(LEVELS);
  localparam int TAW = AW + LW;
  localparam logic [LW-1:0] LVL_TOP = LW'(LEVELS - 1);

  typedef enum logic [11:0] {
    ST_IDLE = 12'b000000000001,
    ST_BRD1 = 12'b000000000010,
    ST_BRD2 = 12'b000000000100,
    ST_BWR  = 12'b000000001000,
    ST_QSWP = 12'b000000010000,
    ST_QL1  = 12'b000000100000,
    ST_QL2  = 12'b000001000000,
    ST_QL3  = 12'b000010000000,
    ST_QEQ  = 12'b000100000000,
    ST_QP1  = 12'b001000000000,
    ST_QP2  = 12'b010000000000,
    ST_QP3  = 12'b100000000000
  } state_t;

  // Final parent read, depth read and result hand-off are tracked by three extra flags.
  state_t state_r, state_nxt;
  logic   fin1_r, fin1_nxt;
  logic   fin2_r, fin2_nxt;
  logic   outw_r, outw_nxt;

  lca_pkg::count_t cnt_r;
  lca_pkg::node_t  root_r;
  lca_pkg::count_t n_r, n_nxt;
  lca_pkg::count_t i_r, i_nxt;
  logic [LW-1:0]   lvl_r, lvl_nxt;
  lca_pkg::node_t  a_r, a_nxt, b_r, b_nxt, t_r, t_nxt, da_r, da_nxt;
  lca_pkg::node_t  anc_r, anc_nxt;

  logic            out_valid_r;
  lca_pkg::node_t  out_node_r, out_depth_r;

  // Memory port signals.
  logic            t_we, t_re, d_we, d_re;
  logic [TAW-1:0]  t_waddr, t_raddr;
  lca_pkg::node_t  t_wdata, t_rraw, d_wdata, d_rraw0, d_rraw1;
  lca_pkg::node_t  t_rd_node, d_rd0_node, d_rd1_node;
  logic            t_oor_r, d_oor0_r, d_oor1_r;
  lca_pkg::node_t  tq, dq0, dq1;

  logic            accept;
  lca_pkg::count_t n_lim;

  function automatic logic in_rng(lca_pkg::node_t v);
    return (32'(v) < 32'(MAX_NODES));
  endfunction

  function automatic logic [TAW-1:0] tadr(lca_pkg::node_t v, logic [LW-1:0] l);
    return {AW'(v), l};
  endfunction

  // Both build reads fetch the level below the one being written.
  assign t_raddr = tadr(t_rd_node,
                        (state_r == ST_BRD1 || state_r == ST_BRD2) ? lvl_r - 1'b1 : lvl_r);

  lca_anc_mem #(.ADDR_W(TAW)) u_anc (
    .clk(clk), .wr_en(t_we), .wr_addr(t_waddr), .wr_data(t_wdata),
    .rd_en(t_re), .rd_addr(t_raddr),
    .rd_data(t_rraw)
  );

  lca_dep_mem #(.ADDR_W(AW)) u_dep (
    .clk(clk), .wr_en(d_we), .wr_addr(AW'(in_ch.node)), .wr_data(d_wdata),
    .rd_en(d_re), .rd_addr0(AW'(d_rd0_node)), .rd_addr1(AW'(d_rd1_node)),
    .rd_data0(d_rraw0), .rd_data1(d_rraw1)
  );

  // Entries beyond the node range read as zero.
  assign tq  = t_oor_r  ? '0 : t_rraw;
  assign dq0 = d_oor0_r ? '0 : d_rraw0;
  assign dq1 = d_oor1_r ? '0 : d_rraw1;

  always_ff @(posedge clk) begin
    if (t_re) begin
      t_oor_r <= !in_rng(t_rd_node);
    end
    if (d_re) begin
      d_oor0_r <= !in_rng(d_rd0_node);
      d_oor1_r <= !in_rng(d_rd1_node);
    end
  end

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE) && !fin1_r && !fin2_r && !outw_r;
  assign cfg_ch.ready = 1'b1;
  assign n_lim = (32'(cnt_r) > 32'(MAX_NODES)) ? lca_pkg::count_t'(MAX_NODES) : cnt_r;

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    fin1_nxt   = fin1_r;
    fin2_nxt   = fin2_r;
    outw_nxt   = outw_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    lvl_nxt    = lvl_r;
    a_nxt      = a_r;
    b_nxt      = b_r;
    t_nxt      = t_r;
    da_nxt     = da_r;
    anc_nxt    = anc_r;
    t_we       = 1'b0;
    t_waddr    = tadr(in_ch.node, '0);
    t_wdata    = (in_ch.node == root_r) ? in_ch.node : in_ch.parent_node;
    t_re       = 1'b0;
    t_rd_node  = b_r;
    d_we       = 1'b0;
    d_wdata    = in_ch.node_depth;
    d_re       = 1'b0;
    d_rd0_node = in_ch.left_node;
    d_rd1_node = in_ch.right_node;

    unique case (state_r)
      ST_IDLE: begin
        if (fin1_r) begin
          // Final parent read.
          t_re      = 1'b1;
          t_rd_node = a_r;
          fin1_nxt  = 1'b0;
          fin2_nxt  = 1'b1;
        end else if (fin2_r) begin
          anc_nxt    = tq;
          d_re       = 1'b1;
          d_rd0_node = tq;
          fin2_nxt   = 1'b0;
          outw_nxt   = 1'b1;
        end else if (accept) begin
          case (in_ch.func)
            lca_pkg::FUNC_LOAD: begin
              if (in_rng(in_ch.node)) begin
                t_we = 1'b1;
                d_we = 1'b1;
              end
            end
            lca_pkg::FUNC_BUILD: begin
              // Root is forced to be its own parent.
              t_waddr = tadr(root_r, '0);
              t_wdata = root_r;
              t_we    = in_rng(root_r);
              n_nxt   = n_lim;
              i_nxt   = '0;
              lvl_nxt = LW'(1);
              if (n_lim != '0) begin
                state_nxt = ST_BRD1;
              end
            end
            lca_pkg::FUNC_QUERY: begin
              d_re      = 1'b1;
              a_nxt     = in_ch.left_node;
              b_nxt     = in_ch.right_node;
              state_nxt = ST_QSWP;
            end
            default: ;
          endcase
        end
      end
      ST_BRD1: begin
        t_re      = 1'b1;
        t_rd_node = lca_pkg::NODE_W'(i_r);
        state_nxt = ST_BRD2;
      end
      ST_BRD2: begin
        t_re      = 1'b1;
        t_rd_node = tq;
        state_nxt = ST_BWR;
      end
      ST_BWR: begin
        t_we    = 1'b1;
        t_waddr = {AW'(i_r), lvl_r};
        t_wdata = tq;
        state_nxt = ST_BRD1;
        if (i_r + 1'b1 == n_r) begin
          i_nxt = '0;
          if (lvl_r == LVL_TOP) begin
            state_nxt = ST_IDLE;
          end else begin
            lvl_nxt = lvl_r + 1'b1;
          end
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_QSWP: begin
        // Make b the deeper node.
        if (dq0 > dq1) begin
          a_nxt  = b_r;
          b_nxt  = a_r;
          da_nxt = dq1;
        end else begin
          da_nxt = dq0;
        end
        lvl_nxt   = LVL_TOP;
        state_nxt = ST_QL1;
      end
      ST_QL1: begin
        t_re      = 1'b1;
        t_rd_node = b_r;
        state_nxt = ST_QL2;
      end
      ST_QL2: begin
        t_nxt      = tq;
        d_re       = 1'b1;
        d_rd0_node = tq;
        d_rd1_node = tq;
        state_nxt  = ST_QL3;
      end
      ST_QL3: begin
        if (dq0 >= da_r) begin
          b_nxt = t_r;
        end
        if (lvl_r == '0) begin
          state_nxt = ST_QEQ;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = ST_QL1;
        end
      end
      ST_QEQ: begin
        if (a_r == b_r) begin
          anc_nxt    = a_r;
          d_re       = 1'b1;
          d_rd0_node = a_r;
          d_rd1_node = a_r;
          outw_nxt   = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          lvl_nxt   = LVL_TOP;
          state_nxt = ST_QP1;
        end
      end
      ST_QP1: begin
        t_re      = 1'b1;
        t_rd_node = a_r;
        state_nxt = ST_QP2;
      end
      ST_QP2: begin
        t_nxt     = tq;
        t_re      = 1'b1;
        t_rd_node = b_r;
        state_nxt = ST_QP3;
      end
      ST_QP3: begin
        if (t_r != tq) begin
          a_nxt = t_r;
          b_nxt = tq;
        end
        if (lvl_r == '0) begin
          fin1_nxt  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          lvl_nxt   = lvl_r - 1'b1;
          state_nxt = ST_QP1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // Result hand-off once the output register is free.
    if (outw_r && (!out_valid_r || out_ch.ready)) begin
      outw_nxt = 1'b0;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fin1_r      <= 1'b0;
      fin2_r      <= 1'b0;
      outw_r      <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= lca_pkg::COUNT_RST;
      root_r      <= lca_pkg::ROOT_RST;
    end else begin
      state_r <= state_nxt;
      fin1_r  <= fin1_nxt;
      fin2_r  <= fin2_nxt;
      outw_r  <= outw_nxt;
      if (outw_r && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          lca_pkg::REG_NODE_COUNT: cnt_r  <= cfg_ch.data;
          lca_pkg::REG_ROOT_NODE:  root_r <= lca_pkg::NODE_W'(cfg_ch.data);
          default: ;
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    n_r   <= n_nxt;
    i_r   <= i_nxt;
    lvl_r <= lvl_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    t_r   <= t_nxt;
    da_r  <= da_nxt;
    anc_r <= anc_nxt;
    if (outw_r && (!out_valid_r || out_ch.ready)) begin
      out_node_r  <= anc_r;
      out_depth_r <= dq0;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.ancestor_node  = out_node_r;
  assign out_ch.ancestor_depth = out_depth_r;

endmodule

[rtl/lca_anc_mem.sv]
// ----------------------------------------------------------------------------
// lca_anc_mem: ancestor table memory
// One write port and one registered read port; read data holds without rd_en.
// ----------------------------------------------------------------------------
module lca_anc_mem #(
  parameter int ADDR_W = 14
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  lca_pkg::node_t      wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr,
  output lca_pkg::node_t      rd_data
);

  lca_pkg::node_t mem [1<<ADDR_W];
  lca_pkg::node_t rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[rtl/lca_dep_mem.sv]
// ----------------------------------------------------------------------------
// lca_dep_mem: node depth memory
// One write port and two registered read ports sharing one read enable.
// ----------------------------------------------------------------------------
module lca_dep_mem #(
  parameter int ADDR_W = 10
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [ADDR_W-1:0]   wr_addr,
  input  lca_pkg::node_t      wr_data,
  input  logic                rd_en,
  input  logic [ADDR_W-1:0]   rd_addr0,
  input  logic [ADDR_W-1:0]   rd_addr1,
  output lca_pkg::node_t      rd_data0,
  output lca_pkg::node_t      rd_data1
);

  lca_pkg::node_t mem [1<<ADDR_W];
  lca_pkg::node_t rd_data0_r;
  lca_pkg::node_t rd_data1_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Two read ports.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data0_r <= mem[rd_addr0];
      rd_data1_r <= mem[rd_addr1];
    end
  end

  assign rd_data0 = rd_data0_r;
  assign rd_data1 = rd_data1_r;

endmodule

[bench/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: lowest common ancestor block
// Loads hand-made and random rooted trees, builds the ancestor table and sends queries
// through bursty input and stalling output channels. A scoreboard predicts
// every ancestor word and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lca_pkg::*;

  localparam int NODES = MAX_NODES_DEF;
  localparam int LVLS  = LEVELS_DEF;

  typedef struct packed {
    node_t anc;
    node_t dep;
  } lca_word_t;

  // Scoreboard: its own copy of the ancestor table, depths and registers.
  class lca_scoreboard;
    node_t     lift_tab[NODES][LVLS];
    node_t     depth_mem[NODES];
    int        count_reg;
    node_t     root_reg;
    lca_word_t due[$];
    int        errors;

    function new();
      count_reg = int'(COUNT_RST);
      root_reg  = ROOT_RST;
      errors    = 0;
    endfunction

    function void set_reg(cidx_t idx, cdat_t data);
      if (idx == REG_NODE_COUNT) count_reg = int'(data);
      else if (idx == REG_ROOT_NODE) root_reg = data[NODE_W-1:0];
    endfunction

    function void build_table();
      int n;
      n = (count_reg > NODES) ? NODES : count_reg;
      lift_tab[root_reg][0] = root_reg;
      for (int j = 1; j < LVLS; j++)
        for (int i = 0; i < n; i++)
          lift_tab[i][j] = lift_tab[lift_tab[i][j-1]][j-1];
    endfunction

    function node_t common_ancestor(node_t l, node_t r);
      node_t a, b, t;
      a = l;
      b = r;
      if (depth_mem[a] > depth_mem[b]) begin
        t = a; a = b; b = t;
      end
      // Bring the deeper node up to the depth of the other.
      for (int i = LVLS - 1; i >= 0; i--) begin
        t = lift_tab[b][i];
        if (depth_mem[t] >= depth_mem[a]) b = t;
      end
      if (a == b) return a;
      // Lift both while their ancestors still differ.
      for (int i = LVLS - 1; i >= 0; i--) begin
        if (lift_tab[a][i] != lift_tab[b][i]) begin
          a = lift_tab[a][i];
          b = lift_tab[b][i];
        end
      end
      return lift_tab[a][0];
    endfunction

    function void note_word(func_t f, node_t v, node_t p, node_t d, node_t l, node_t r);
      lca_word_t w;
      case (f)
        FUNC_LOAD: begin
          lift_tab[v][0] = (v == root_reg) ? v : p;
          depth_mem[v]   = d;
        end
        FUNC_BUILD: build_table();
        FUNC_QUERY: begin
          w.anc = common_ancestor(l, r);
          w.dep = depth_mem[w.anc];
          due = {due, w};
        end
        default: ;
      endcase
    endfunction

    function void check_result(node_t anc, node_t dep);
      lca_word_t w;
      if (due.size() == 0) begin
        $error("unexpected result word: ancestor_node %0d ancestor_depth %0d", anc, dep);
        errors++;
        return;
      end
      w = due.pop_front();
      if (anc !== w.anc) begin
        $error("ancestor_node: expected %0d, actual %0d", w.anc, anc);
        errors++;
      end
      if (dep !== w.dep) begin
        $error("ancestor_depth: expected %0d, actual %0d", w.dep, dep);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  lca_in_if  in_ch ();
  lca_out_if out_ch ();
  lca_cfg_if cfg_ch ();

  tree_lca_binary_lifting uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  lca_scoreboard sb = new();

  int node_dep [NODES];
  int burst_left;
  int results_seen;
  int cur_n;

  // Clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Hard limit on run time.
  initial begin
    #20ms;
    $display("FAIL tree_lca_binary_lifting");
    $finish;
  end

  // Sender pacing: bursts of random length with random gaps.
  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom % 4 == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
  endtask

  task automatic send_word(func_t f, node_t v, node_t p, node_t d, node_t l, node_t r);
    logic ok;
    pace();
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.node        <= v;
    in_ch.parent_node <= p;
    in_ch.node_depth  <= d;
    in_ch.left_node   <= l;
    in_ch.right_node  <= r;
    do begin
      @(negedge clk);
      ok = in_ch.ready;
      @(posedge clk);
    end while (!ok);
    sb.note_word(f, v, p, d, l, r);
  endtask

  task automatic write_reg(cidx_t idx, cdat_t data);
    logic ok;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do begin
      @(negedge clk);
      ok = cfg_ch.ready;
      @(posedge clk);
    end while (!ok);
    cfg_ch.valid <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  // Wait until every expected word has arrived and the block is quiet.
  task automatic settle();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic load_node(node_t v, node_t p, int d);
    node_dep[v] = d;
    send_word(FUNC_LOAD, v, p, node_t'(d), node_t'($urandom), node_t'($urandom));
  endtask

  task automatic query(node_t l, node_t r);
    send_word(FUNC_QUERY, node_t'($urandom), node_t'($urandom), node_t'($urandom), l, r);
  endtask

  task automatic build();
    send_word(FUNC_BUILD, node_t'($urandom), node_t'($urandom), node_t'($urandom),
              node_t'($urandom), node_t'($urandom));
  endtask

  // Load a random tree over nodes 0..n-1; deep trees mostly chain.
  task automatic grow_tree(int n, node_t root, bit deep);
    node_t placed[$];
    node_t p;
    load_node(root, node_t'($urandom), 0);
    placed = {placed, root};
    for (int i = 0; i < n; i++) begin
      if (i == root) continue;
      if (deep && ($urandom % 10 != 0)) p = placed[placed.size() - 1];
      else p = placed[$urandom % placed.size()];
      load_node(node_t'(i), p, node_dep[p] + 1);
      placed = {placed, node_t'(i)};
    end
  endtask

  // Queries with a little noise: idle codes and reloaded nodes.
  task automatic run_queries(int n, int k);
    node_t l, r;
    int pick;
    for (int q = 0; q < k; q++) begin
      pick = $urandom % 100;
      if (pick < 6) begin
        send_word(FUNC_NOP, node_t'($urandom), node_t'($urandom), node_t'($urandom),
                  node_t'($urandom), node_t'($urandom));
      end else if (pick < 9) begin
        load_node(node_t'($urandom % n), node_t'($urandom % n), $urandom % NODES);
      end else begin
        l = node_t'($urandom % n);
        r = ($urandom % 10 == 0) ? l : node_t'($urandom % n);
        query(l, r);
      end
    end
    query(node_t'($urandom % n), node_t'($urandom % n));
  endtask

  task automatic tree_phase(int n, cdat_t count_data, node_t root, bit deep, int k);
    write_reg(REG_NODE_COUNT, count_data);
    write_reg(REG_ROOT_NODE, {1'($urandom), root});
    cur_n = n;
    grow_tree(n, root, deep);
    build();
    run_queries(n, k);
    settle();
  endtask

  // Receiver: stall pattern plus one long hold-off to back up the block.
  initial begin : receiver
    logic hit;
    node_t anc, dep;
    int cyc, hold;
    bit held;
    cyc = 0;
    hold = 0;
    held = 0;
    results_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      hit = out_ch.valid && out_ch.ready;
      anc = out_ch.ancestor_node;
      dep = out_ch.ancestor_depth;
      @(posedge clk);
      if (hit && rst_n) begin
        sb.check_result(anc, dep);
        results_seen++;
      end
      if (!held && results_seen == 100) begin
        held = 1;
        hold = 400;
      end
      cyc++;
      if (hold > 0) begin
        hold--;
        out_ch.ready <= 1'b0;
      end else if ((cyc / 64) % 3 == 0) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= (cyc % 7 >= 2) && ($urandom % 4 != 0);
      end
    end
  end

  // Main stimulus.
  initial begin : stimulus
    int n;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.func   = FUNC_NOP;
    in_ch.node   = '0;
    in_ch.parent_node = '0;
    in_ch.node_depth  = '0;
    in_ch.left_node   = '0;
    in_ch.right_node  = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = REG_NODE_COUNT;
    cfg_ch.data  = '0;
    burst_left   = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // A single node that is its own root; the given parent is overridden.
    write_reg(REG_NODE_COUNT, 11'd1);
    write_reg(REG_ROOT_NODE, 11'd0);
    load_node(10'd0, 10'd1023, 0);
    build();
    query(10'd0, 10'd0);
    settle();

    // Small hand-made tree rooted at node 2, queried in both orders.
    write_reg(REG_NODE_COUNT, 11'd4);
    write_reg(REG_ROOT_NODE, 11'd2);
    load_node(10'd2, 10'd5, 0);
    load_node(10'd0, 10'd2, 1);
    load_node(10'd1, 10'd0, 2);
    load_node(10'd3, 10'd2, 1);
    send_word(FUNC_NOP, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023);
    build();
    query(10'd1, 10'd3);
    query(10'd3, 10'd1);
    query(10'd1, 10'd1);
    query(10'd0, 10'd1);
    query(10'd2, 10'd1);
    settle();

    // Move the root after loading: the build forces the new root on itself.
    write_reg(REG_ROOT_NODE, 11'd3);
    build();
    query(10'd1, 10'd3);
    query(10'd0, 10'd2);
    settle();

    // A zero node count builds no table levels; the old table stays in use.
    write_reg(REG_NODE_COUNT, 11'd0);
    build();
    query(10'd1, 10'd0);
    settle();

    // Random trees of modest size.
    for (int ph = 0; ph < 4; ph++) begin
      n = $urandom_range(2, 48);
      tree_phase(n, cdat_t'(n), node_t'($urandom % n), 1'($urandom % 2), 30);
      if (ph == 1) begin
        write_reg(REG_NODE_COUNT, 11'd0);
        build();
        run_queries(cur_n, 10);
        settle();
      end
    end

    // Full-size deep tree with an oversized node count and the top root.
    tree_phase(NODES, 11'd2047, 10'd1023, 1'b1, 60);

    if (sb.errors == 0) begin
      $display("PASS tree_lca_binary_lifting");
    end else begin
      $display("FAIL tree_lca_binary_lifting");
    end
    $finish;
  end

endmodule
